@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on aclk and masked while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must never be seen on aclk while out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ rtl/pahc_pkg.sv @@
`timescale 1ns / 1ps

package pahc_pkg;

    // Field widths
    localparam int SETP_W  = 16;
    localparam int KP_W    = 10;
    localparam int PG_W    = 16;
    localparam int FMAX_W  = 8;
    localparam int LIM_W   = 16;
    localparam int ADC_W   = 10;
    localparam int CNT_W   = 16;
    localparam int DRIVE_W = 16;
    localparam int TEMP_W  = 17;
    localparam int ERR_W   = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Serial MAC: accumulator covers drive + kp * (err + prev_err * gain)
    localparam int ACC_W  = 48;
    localparam int MPL_W  = 16;
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] MUL1_STEPS = STEP_W'(PG_W);
    localparam logic [STEP_W-1:0] MUL2_STEPS = STEP_W'(KP_W);

    // Register reset values
    localparam logic [SETP_W-1:0] SETPOINT_RST      = 16'd12800;
    localparam logic [KP_W-1:0]   KP_RST            = 10'd100;
    localparam logic [PG_W-1:0]   PREV_GAIN_RST     = 16'd999;
    localparam logic [FMAX_W-1:0] FIRE_MAX_RST      = 8'd84;
    localparam logic [LIM_W-1:0]  CONTROL_LIMIT_RST = 16'd100;
    localparam logic [LIM_W-1:0]  SAMPLE_LIMIT_RST  = 16'd1000;

    // Command codes carried in s_tuser
    localparam logic CMD_TICK       = 1'b0;
    localparam logic CMD_ZERO_CROSS = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT      = 3'd0,
        CFG_KP            = 3'd1,
        CFG_PREV_GAIN     = 3'd2,
        CFG_FIRE_MAX      = 3'd3,
        CFG_CONTROL_LIMIT = 3'd4,
        CFG_SAMPLE_LIMIT  = 3'd5
    } cfg_idx_t;

    // Request into the serial multiply-accumulate unit
    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] acc_init;
        logic signed [ACC_W-1:0] mcand;
        logic [MPL_W-1:0]        mplier;
        logic [STEP_W-1:0]       steps;
    } mac_req_t;

    // Status back from the serial unit
    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } mac_rsp_t;

endpackage

@@ rtl/pahc_mac.sv @@
`timescale 1ns / 1ps

// Bit-serial shift-add multiply-accumulate: acc += mcand * mplier,
// one multiplier bit per cycle, LSB first.
module pahc_mac (
    input  logic               aclk,
    input  logic               aresetn,
    input  pahc_pkg::mac_req_t req,
    output pahc_pkg::mac_rsp_t rsp
);

    logic signed [pahc_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [pahc_pkg::ACC_W-1:0] mcand_reg, mcand_next;
    logic [pahc_pkg::MPL_W-1:0]        mplier_reg, mplier_next;
    logic [pahc_pkg::STEP_W-1:0]       count_reg, count_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;

    // One step per cycle while busy
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        count_next  = count_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start) begin
            acc_next    = req.acc_init;
            mcand_next  = req.mcand;
            mplier_next = req.mplier;
            count_next  = req.steps;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            count_next  = count_reg - 1'b1;
            if (count_reg == pahc_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;

endmodule

@@ rtl/phase_angle_heater_controller_top.sv @@
// Zero crossings and ticks without a controller update go from ST_IDLE to ST_EMIT; a tick
// that runs the controller update passes ST_LOAD1, ST_MUL1, ST_LOAD2 and ST_MUL2 first.
// A new request is taken only in ST_IDLE, after ST_EMIT has loaded the result register; the update
// runs on the bit-serial MAC (16 steps for the previous-error weight, 10 for kp).
// Reset: aresetn synchronous, active low; clears controller state, flags and m_tvalid and loads
// register defaults (err_reg, m_tdata, m_tuser and the MAC datapath are not reset), no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phase_angle_heater_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_sample
    input  logic [0:0]  s_tuser,   // [0] command
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] gate_on, [16:1] drive_level, [33:17] temperature,
                                   // [51:34] error_value
    output logic [1:0]  m_tuser,   // [0] control_updated, [1] sample_taken
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD1,
        ST_MUL1,
        ST_LOAD2,
        ST_MUL2,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [pahc_pkg::SETP_W-1:0] setpoint_reg;
    logic [pahc_pkg::KP_W-1:0]   kp_reg;
    logic [pahc_pkg::PG_W-1:0]   prev_gain_reg;
    logic [pahc_pkg::FMAX_W-1:0] fire_max_reg;
    logic [pahc_pkg::LIM_W-1:0]  control_limit_reg;
    logic [pahc_pkg::LIM_W-1:0]  sample_limit_reg;

    // Controller state
    logic                               armed_reg;
    logic                               gate_level_reg;
    logic [pahc_pkg::CNT_W-1:0]         fire_count_reg;
    logic [pahc_pkg::CNT_W-1:0]         control_count_reg;
    logic [pahc_pkg::CNT_W-1:0]         sample_count_reg;
    logic [pahc_pkg::TEMP_W-1:0]        temp_value_reg;
    logic signed [pahc_pkg::ERR_W-1:0]  prev_error_reg;
    logic [pahc_pkg::DRIVE_W-1:0]       drive_value_reg;
    logic signed [pahc_pkg::ERR_W-1:0]  err_reg;
    logic                               ctl_flag_reg;
    logic                               smp_flag_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    pahc_pkg::mac_req_t mac_req;
    pahc_pkg::mac_rsp_t mac_rsp;

    logic                               s_fire;
    logic [pahc_pkg::ADC_W-1:0]         adc_in;
    logic [pahc_pkg::TEMP_W-1:0]        adc_ext;
    logic [pahc_pkg::TEMP_W-1:0]        temp_next;
    logic signed [pahc_pkg::ERR_W-1:0]  err_next;
    logic signed [24:0]                 fire_old_scaled;
    logic signed [24:0]                 fire_ref;
    logic                               fire_hit;
    logic                               ctl_hit;
    logic                               smp_hit;
    logic signed [pahc_pkg::ACC_W-1:0]  drive_top;
    logic [pahc_pkg::DRIVE_W-1:0]       drive_next;
    logic                               out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign adc_in    = s_tdata[pahc_pkg::ADC_W-1:0];

    // adc * 125 as (adc << 7) - (adc << 2) + adc
    assign adc_ext   = {{(pahc_pkg::TEMP_W-pahc_pkg::ADC_W){1'b0}}, adc_in};
    assign temp_next = (adc_ext << 7) - (adc_ext << 2) + adc_ext;

    // Error against the temperature held before this tick
    assign err_next = $signed({2'b00, setpoint_reg}) - $signed({1'b0, temp_value_reg});

    // Firing check: old*256 > fire_max*256 - drive
    assign fire_old_scaled = $signed({1'b0, fire_count_reg, 8'h00});
    assign fire_ref        = $signed({9'h000, fire_max_reg, 8'h00})
                           - $signed({9'h000, drive_value_reg});
    assign fire_hit        = fire_old_scaled > fire_ref;

    // Period counters compare the old count
    assign ctl_hit = control_count_reg > control_limit_reg;
    assign smp_hit = sample_count_reg > sample_limit_reg;

    // Clamp of the accumulated drive to 0..fire_max*256
    assign drive_top = $signed({32'h0, fire_max_reg, 8'h00});
    always_comb begin
        priority if (mac_rsp.acc[pahc_pkg::ACC_W-1]) begin
            drive_next = '0;
        end else if (mac_rsp.acc > drive_top) begin
            drive_next = drive_top[pahc_pkg::DRIVE_W-1:0];
        end else begin
            drive_next = mac_rsp.acc[pahc_pkg::DRIVE_W-1:0];
        end
    end

    // MAC requests: term = err + prev_err * prev_gain, then drive + kp * term
    always_comb begin
        mac_req.start    = 1'b0;
        mac_req.acc_init = {{(pahc_pkg::ACC_W-pahc_pkg::ERR_W){err_reg[pahc_pkg::ERR_W-1]}},
                            err_reg};
        mac_req.mcand    = {{(pahc_pkg::ACC_W-pahc_pkg::ERR_W){
                              prev_error_reg[pahc_pkg::ERR_W-1]}}, prev_error_reg};
        mac_req.mplier   = prev_gain_reg;
        mac_req.steps    = pahc_pkg::MUL1_STEPS;
        if (state_reg == ST_LOAD1) begin
            mac_req.start = 1'b1;
        end else if (state_reg == ST_LOAD2) begin
            mac_req.start    = 1'b1;
            mac_req.acc_init = {{(pahc_pkg::ACC_W-pahc_pkg::DRIVE_W){1'b0}}, drive_value_reg};
            mac_req.mcand    = mac_rsp.acc;
            mac_req.mplier   = {{(pahc_pkg::MPL_W-pahc_pkg::KP_W){1'b0}}, kp_reg};
            mac_req.steps    = pahc_pkg::MUL2_STEPS;
        end
    end

    pahc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mac_req),
        .rsp     (mac_rsp)
    );

    // Sequencer, controller state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            setpoint_reg      <= pahc_pkg::SETPOINT_RST;
            kp_reg            <= pahc_pkg::KP_RST;
            prev_gain_reg     <= pahc_pkg::PREV_GAIN_RST;
            fire_max_reg      <= pahc_pkg::FIRE_MAX_RST;
            control_limit_reg <= pahc_pkg::CONTROL_LIMIT_RST;
            sample_limit_reg  <= pahc_pkg::SAMPLE_LIMIT_RST;
            armed_reg         <= 1'b0;
            gate_level_reg    <= 1'b0;
            fire_count_reg    <= '0;
            control_count_reg <= '0;
            sample_count_reg  <= '0;
            temp_value_reg    <= '0;
            prev_error_reg    <= '0;
            drive_value_reg   <= '0;
            ctl_flag_reg      <= 1'b0;
            smp_flag_reg      <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            // Register writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    pahc_pkg::CFG_SETPOINT:      setpoint_reg      <= cfg_data;
                    pahc_pkg::CFG_KP:            kp_reg            <= cfg_data[pahc_pkg::KP_W-1:0];
                    pahc_pkg::CFG_PREV_GAIN:     prev_gain_reg     <= cfg_data;
                    pahc_pkg::CFG_FIRE_MAX:      fire_max_reg      <= cfg_data[pahc_pkg::FMAX_W-1:0];
                    pahc_pkg::CFG_CONTROL_LIMIT: control_limit_reg <= cfg_data;
                    pahc_pkg::CFG_SAMPLE_LIMIT:  sample_limit_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // Result taken; the emit state reloads the register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_tuser[0] == pahc_pkg::CMD_ZERO_CROSS) begin
                            armed_reg      <= 1'b1;
                            gate_level_reg <= 1'b0;
                            fire_count_reg <= '0;
                            ctl_flag_reg   <= 1'b0;
                            smp_flag_reg   <= 1'b0;
                            state_reg      <= ST_EMIT;
                        end else begin
                            // firing check
                            if (armed_reg) begin
                                if (fire_hit) begin
                                    gate_level_reg <= 1'b1;
                                    armed_reg      <= 1'b0;
                                    fire_count_reg <= '0;
                                end else begin
                                    fire_count_reg <= fire_count_reg + 1'b1;
                                end
                            end
                            // control period
                            ctl_flag_reg <= ctl_hit;
                            err_reg      <= err_next;
                            if (ctl_hit) begin
                                control_count_reg <= '0;
                                state_reg         <= ST_LOAD1;
                            end else begin
                                control_count_reg <= control_count_reg + 1'b1;
                                state_reg         <= ST_EMIT;
                            end
                            // sample period
                            smp_flag_reg <= smp_hit;
                            if (smp_hit) begin
                                sample_count_reg <= '0;
                                temp_value_reg   <= temp_next;
                            end else begin
                                sample_count_reg <= sample_count_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_LOAD1: begin
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    if (mac_rsp.done) begin
                        state_reg <= ST_LOAD2;
                    end
                end
                ST_LOAD2: begin
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    if (mac_rsp.done) begin
                        drive_value_reg <= drive_next;
                        prev_error_reg  <= err_reg;
                        state_reg       <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'h0, prev_error_reg, temp_value_reg,
                                         drive_value_reg, gate_level_reg};
                        m_tuser_reg  <= {smp_flag_reg, ctl_flag_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `ASSERT_CLK(a_mac_idle_when_ready, s_tready |-> !mac_rsp.busy, "MAC busy while taking input")
    `ASSERT_NEVER(a_gate_and_armed, gate_level_reg && armed_reg, "gate high while still armed")
    `ASSERT_CLK(a_mac_done_in_mul, mac_rsp.done |-> (state_reg == ST_MUL1 || state_reg == ST_MUL2), "MAC done outside multiply")
    `ASSERT_CLK(a_emit_loads_output, (state_reg == ST_EMIT && out_free) |=> m_tvalid, "result not presented")

endmodule
